// ===== hdl/lpit_pkg.sv =====
// ---------------------------------------------------------------------------
// lpit_pkg
// Shared constants for the linear probing identifier table: status codes,
// the empty slot marker and default sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package lpit_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned STATUS_W = 3;

    localparam int unsigned TABLE_SLOTS_DEF = 2048;
    localparam int unsigned MAX_ENTRIES_DEF = 1024;

    localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

    localparam logic KIND_LOOKUP   = 1'b0;
    localparam logic KIND_REGISTER = 1'b1;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_HIT      = 3'd0;
    localparam t_status ST_INSERTED = 3'd1;
    localparam t_status ST_MISS     = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_RESERVED = 3'd4;

endpackage

`default_nettype wire

// ===== hdl/linear_probe_id_table.sv =====
// ---------------------------------------------------------------------------
// linear_probe_id_table
// Open addressing table of 32-bit identifiers with linear probing. Lookup
// returns the dense index stored with a key; register inserts a new key at
// the first empty slot on its probe path and gives it the next dense index.
//
//   channel   signals                    direction  transaction
//   request   start, i_kind, i_key       in         start && !busy
//   result    o_done, o_status,          out        o_done (one cycle)
//             o_entry_index
//
// A reserved key or a register at the entry limit is answered without
// probing; else the table reads slots along the probe path, one slot
// read per cycle through the single slot RAM port, at most TABLE_SLOTS slots.
// The result strobe follows in the cycle after the decision; busy is low then.
// After reset a clearing pass writes the empty marker to every slot, with busy high.
// The receiver cannot stall results.
// ---------------------------------------------------------------------------
`default_nettype none

module linear_probe_id_table #(
    parameter int unsigned TABLE_SLOTS = lpit_pkg::TABLE_SLOTS_DEF,
    parameter int unsigned MAX_ENTRIES = lpit_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_kind,
    input  wire logic [lpit_pkg::KEY_W-1:0]    i_key,
    output logic                               o_done,
    output lpit_pkg::t_status                  o_status,
    output logic      [lpit_pkg::INDEX_W-1:0]  o_entry_index
);

    localparam int unsigned KW = lpit_pkg::KEY_W;
    localparam int unsigned IW = lpit_pkg::INDEX_W;
    localparam int unsigned SW = $clog2(TABLE_SLOTS);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned XW = (CW > IW) ? CW : IW;
    localparam int unsigned RW = KW + IW;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } t_state;

    t_state            r_state, n_state;
    logic [SW-1:0]     r_clr, n_clr;
    logic [SW-1:0]     r_pos, n_pos;
    logic [SW-1:0]     r_visit, n_visit;
    logic [KW-1:0]     r_key, n_key;
    logic              r_kind, n_kind;
    logic [CW-1:0]     r_count, n_count;
    logic              r_done, n_done;
    lpit_pkg::t_status r_status, n_status;
    logic [IW-1:0]     r_index, n_index;

    logic              ram_we;
    logic [SW-1:0]     ram_addr;
    logic [RW-1:0]     ram_wdata;
    logic [RW-1:0]     ram_rdata;
    logic [KW-1:0]     rd_key;
    logic [IW-1:0]     rd_index;
    logic [XW-1:0]     cnt_ext;
    logic [IW-1:0]     cnt_index;
    logic              accept;
    logic              at_limit;

    lpit_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[RW-1:IW];
    assign rd_index  = ram_rdata[IW-1:0];
    assign cnt_ext   = XW'(r_count);
    assign cnt_index = cnt_ext[IW-1:0];
    assign at_limit  = (r_count >= CW'(MAX_ENTRIES));
    assign accept    = start && !busy;

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_index = r_index;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_pos     = r_pos;
        n_visit   = r_visit;
        n_key     = r_key;
        n_kind    = r_kind;
        n_count   = r_count;
        n_done    = 1'b0;
        n_status  = r_status;
        n_index   = r_index;
        ram_we    = 1'b0;
        ram_addr  = r_pos;
        ram_wdata = {r_key, cnt_index};

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = {lpit_pkg::EMPTY_KEY, {IW{1'b0}}};
                n_clr     = r_clr + 1'b1;
                if (r_clr == SW'(TABLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_addr = i_key[SW-1:0];
                if (accept) begin
                    n_key   = i_key;
                    n_kind  = i_kind;
                    n_pos   = i_key[SW-1:0];
                    n_visit = '0;
                    if (i_key == lpit_pkg::EMPTY_KEY) begin
                        n_done   = 1'b1;
                        n_status = lpit_pkg::ST_RESERVED;
                        n_index  = '0;
                    end else if (i_kind == lpit_pkg::KIND_REGISTER && at_limit) begin
                        n_done   = 1'b1;
                        n_status = lpit_pkg::ST_FULL;
                        n_index  = '0;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                ram_addr = r_pos + 1'b1;
                if (rd_key == r_key) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = lpit_pkg::ST_HIT;
                    n_index  = rd_index;
                end else if (rd_key == lpit_pkg::EMPTY_KEY) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (r_kind == lpit_pkg::KIND_REGISTER) begin
                        // claim the empty slot
                        ram_we   = 1'b1;
                        ram_addr = r_pos;
                        n_count  = r_count + 1'b1;
                        n_status = lpit_pkg::ST_INSERTED;
                        n_index  = cnt_index;
                    end else begin
                        n_status = lpit_pkg::ST_MISS;
                        n_index  = '0;
                    end
                end else if (r_visit == SW'(TABLE_SLOTS - 1)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_index  = '0;
                    n_status = (r_kind == lpit_pkg::KIND_REGISTER) ?
                               lpit_pkg::ST_FULL : lpit_pkg::ST_MISS;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_visit = r_visit + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_pos    <= n_pos;
        r_visit  <= n_visit;
        r_key    <= n_key;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_index  <= n_index;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above limit");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == lpit_pkg::ST_INSERTED) |-> r_count == $past(r_count) + 1'b1)
        else $error("insert without count step");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_done)
        else $error("result during clearing pass");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_done || r_state == S_PROBE))
        else $error("accepted transaction dropped");

    a_probe_key_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> r_key != lpit_pkg::EMPTY_KEY)
        else $error("probing with reserved key");

endmodule

`default_nettype wire

// ===== hdl/lpit_ram.sv =====
// ---------------------------------------------------------------------------
// lpit_ram
// Generic single port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module lpit_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire
